@@ hw/rtl/wavg_pkg.sv @@
// ----------------------------------------------------------------------------
// wavg_pkg
// Shared types and constants of the dual channel window average block.
// ----------------------------------------------------------------------------
package wavg_pkg;

    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int OP_W      = 1;
    localparam int SIDE_W    = 1;
    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int AVERAGE_W = SAMPLE_BITS_DEF;
    localparam int COUNT_W   = $clog2(MAX_WINDOW_DEF + 1);
    localparam int WLEN_W    = 5;

    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 5'd8;

    localparam logic [OP_W-1:0] OP_PUSH  = 1'b0;
    localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SIDE_W-1:0]   side;
        logic [SAMPLE_W-1:0] sample;
    } wavg_req_t;

    typedef struct packed {
        logic [SIDE_W-1:0]    result_side;
        logic [AVERAGE_W-1:0] average;
        logic [COUNT_W-1:0]   fill_count;
    } wavg_rsp_t;

endpackage

@@ hw/rtl/wavg_div.sv @@
// ----------------------------------------------------------------------------
// wavg_div
// Restoring divider, one quotient bit per cycle, for window sum over count.
// ----------------------------------------------------------------------------
module wavg_div
    import wavg_pkg::*;
#(
    parameter int NUM_BITS = 17,
    parameter int DEN_BITS = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_BITS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_BITS - 1);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;

    logic [DEN_BITS:0]   rem_shift;
    logic                fits;

    assign rem_shift = {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign done      = busy_reg && (step_reg == LAST_STEP);
    assign quotient  = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit and subtract where it fits
            rem_next  = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quo_next  = {quo_reg[NUM_BITS-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

@@ hw/rtl/dual_channel_window_average.sv @@
// ----------------------------------------------------------------------------
// dual_channel_window_average_core
// Per-side moving average over a growing window of converter samples.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: a push of a sample into the right (0) or left (1)
//   window, or a clear of both fill counts. A push gives one rsp item with
//   the side, the truncated mean of the filled entries and the fill count;
//   a clear gives none and is done in the cycle it is accepted.
//   The user must write window_length with window_length_we only while the
//   block is idle; the block itself does not enforce it. A push goes from
//   accept through the sum update and the restoring divider, one quotient
//   bit at a time, to the load of the output register and rsp valid.
//   req_ready is high whenever no push is in flight, so one push is in work
//   at a time; clears can follow one per cycle. The finished item sits in an
//   output register; a stalled receiver holds it there, and the next push
//   waits at its last step until the register frees. Reset clears the fill
//   counts and sums and sets the window length to 8; the sample memory is
//   not cleared.
// ----------------------------------------------------------------------------
module dual_channel_window_average_core
    import wavg_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  wavg_req_t         req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output wavg_rsp_t         rsp,
    input  logic              window_length_we,
    input  logic [WLEN_W-1:0] window_length
);

    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_BITS = $clog2(2 * MAX_WINDOW);
    localparam int DEPTH     = 2 * MAX_WINDOW;
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [WLEN_W-1:0]      wlen_reg;
    logic [CNT_BITS-1:0]    count_reg [2];
    logic [SUM_BITS-1:0]    sum_reg   [2];
    logic [PTR_BITS-1:0]    ptr_reg   [2];

    logic                   side_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CNT_BITS-1:0]    new_count_reg;
    logic                   grow_reg;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   rsp_valid_reg;
    wavg_rsp_t              rsp_reg;

    logic                   accept, push, clear;
    logic [SAMPLE_BITS-1:0] samp_in;
    logic [CNT_BITS-1:0]    eff_len, cur_count;
    logic                   grow;
    logic [PTR_BITS-1:0]    cur_ptr, next_ptr, old_idx;
    logic [CNT_BITS:0]      ptr_ext, cnt_ext;
    logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
    logic [SUM_BITS-1:0]    sum_next;
    logic                   div_start, div_done;
    logic [SUM_BITS-1:0]    quotient;
    logic                   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign push      = accept && (req.op == OP_PUSH);
    assign clear     = accept && (req.op == OP_CLEAR);
    assign samp_in   = SAMPLE_BITS'(req.sample);

    // clamp the configured length to 1..MAX_WINDOW
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CNT_BITS'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            eff_len = CNT_BITS'(MAX_WINDOW);
        end
        else
        begin
            eff_len = CNT_BITS'(wlen_reg);
        end
    end

    assign cur_count = count_reg[req.side];
    assign cur_ptr   = ptr_reg[req.side];
    assign grow      = cur_count < eff_len;
    assign next_ptr  = (cur_ptr == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : cur_ptr + PTR_BITS'(1);

    // oldest counted entry sits count places behind the write slot
    assign ptr_ext = (CNT_BITS + 1)'(cur_ptr);
    assign cnt_ext = (CNT_BITS + 1)'(cur_count);
    assign old_idx = (ptr_ext >= cnt_ext) ? PTR_BITS'(ptr_ext - cnt_ext)
                                          : PTR_BITS'(ptr_ext + (CNT_BITS + 1)'(MAX_WINDOW)
                                                      - cnt_ext);

    assign wr_addr = req.side ? ADDR_BITS'(MAX_WINDOW) + ADDR_BITS'(cur_ptr)
                              : ADDR_BITS'(cur_ptr);
    assign rd_addr = req.side ? ADDR_BITS'(MAX_WINDOW) + ADDR_BITS'(old_idx)
                              : ADDR_BITS'(old_idx);

    // read happens before the write lands, so a full window sees its oldest
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rd_data_reg  <= mem[rd_addr];
            mem[wr_addr] <= samp_in;
        end
    end

    assign sum_next = sum_reg[side_reg] + SUM_BITS'(sample_reg)
                      - (grow_reg ? '0 : SUM_BITS'(rd_data_reg));

    assign div_start = (state_reg == ST_SUM);
    assign slot_free = !rsp_valid_reg || rsp_ready;

    wavg_div #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (CNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (new_count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WINDOW_LENGTH_RESET;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            ptr_reg[0]    <= '0;
            ptr_reg[1]    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_length_we)
            begin
                wlen_reg <= window_length;
            end
            if (clear)
            begin
                count_reg[0] <= '0;
                count_reg[1] <= '0;
                sum_reg[0]   <= '0;
                sum_reg[1]   <= '0;
            end
            if (push)
            begin
                ptr_reg[req.side] <= next_ptr;
                if (grow)
                begin
                    count_reg[req.side] <= cur_count + CNT_BITS'(1);
                end
            end
            if (state_reg == ST_SUM)
            begin
                sum_reg[side_reg] <= sum_next;
            end
            if (state_reg == ST_DONE && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            side_reg      <= req.side;
            sample_reg    <= samp_in;
            grow_reg      <= grow;
            new_count_reg <= grow ? cur_count + CNT_BITS'(1) : cur_count;
        end
        if (state_reg == ST_DONE && slot_free)
        begin
            rsp_reg.result_side <= side_reg;
            rsp_reg.average     <= AVERAGE_W'(quotient);
            rsp_reg.fill_count  <= COUNT_W'(new_count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of dual_channel_window_average_core. It drives push and clear
// items over the request channel and runs an internal copy of both side
// windows. Each item the block takes is fed to that copy. The block's
// results are then compared field by field, in order, with what the copy
// works out, or with a directed item's typed-in result. A short table of
// directed items runs first, then random phases, each at its own window length.
// ----------------------------------------------------------------------------
module tb;
    import wavg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 135;
    localparam int LONG_HOLD     = 200;

    typedef struct {
        bit                cfg_write;
        logic [WLEN_W-1:0] cfg_value;
        wavg_req_t         item;
        bit                fixed;
        wavg_rsp_t         fixed_rsp;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    wavg_req_t         req;
    logic              rsp_valid;
    logic              rsp_ready;
    wavg_rsp_t         rsp;
    logic              window_length_we;
    logic [WLEN_W-1:0] window_length;

    // travels with the request payload: a typed-in result replaces the prediction
    bit        req_fixed;
    wavg_rsp_t req_fixed_rsp;

    // copy of the block state
    logic [SAMPLE_W-1:0] side_history [2][MAX_WINDOW_DEF];
    int                  side_fill [2];
    logic [WLEN_W-1:0]   length_setting;

    wavg_rsp_t awaited_averages [$];
    stim_row_t directed_rows [$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned pushes_taken;
    int unsigned clears_taken;
    int unsigned averages_checked;
    int unsigned settings_used;

    bit tx_idle_on;
    bit rx_idle_on;
    bit start_long_hold;

    dual_channel_window_average_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .window_length_we (window_length_we),
        .window_length    (window_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Update one side window for a push; a clear empties both. Returns 1 when
    // the item gives a result.
    function automatic bit advance_side_window(input wavg_req_t item,
                                               output wavg_rsp_t outcome);
        int          limit;
        int          count;
        int unsigned total;
        limit   = length_setting;
        outcome = '0;
        if (limit == 0)
            limit = 1;
        if (limit > MAX_WINDOW_DEF)
            limit = MAX_WINDOW_DEF;
        if (item.op == OP_CLEAR)
        begin
            side_fill[0] = 0;
            side_fill[1] = 0;
            return 1'b0;
        end
        count = side_fill[item.side];
        // a count above a lowered length holds where it is
        if (count < limit)
            count++;
        if (count > MAX_WINDOW_DEF)
            count = MAX_WINDOW_DEF;
        side_fill[item.side] = count;
        for (int i = count - 1; i > 0; i--)
            side_history[item.side][i] = side_history[item.side][i - 1];
        side_history[item.side][0] = item.sample;
        total = 0;
        for (int i = 0; i < count; i++)
            total += side_history[item.side][i];
        outcome.result_side = item.side;
        outcome.average     = AVERAGE_W'(total / count);
        outcome.fill_count  = COUNT_W'(count);
        return 1'b1;
    endfunction

    function automatic stim_row_t push_row(input bit side, input int unsigned sample);
        stim_row_t row;
        row = '{default: '0};
        row.item.op     = OP_PUSH;
        row.item.side   = side;
        row.item.sample = SAMPLE_W'(sample);
        return row;
    endfunction

    function automatic stim_row_t known_row(input bit side, input int unsigned sample,
                                            input int unsigned average,
                                            input int unsigned count);
        stim_row_t row;
        row = push_row(side, sample);
        row.fixed                 = 1'b1;
        row.fixed_rsp.result_side = side;
        row.fixed_rsp.average     = AVERAGE_W'(average);
        row.fixed_rsp.fill_count  = COUNT_W'(count);
        return row;
    endfunction

    function automatic stim_row_t clear_row();
        stim_row_t row;
        row = '{default: '0};
        row.item.op = OP_CLEAR;
        return row;
    endfunction

    function automatic stim_row_t length_row(input int unsigned value);
        stim_row_t row;
        row = '{default: '0};
        row.cfg_write = 1'b1;
        row.cfg_value = WLEN_W'(value);
        return row;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: %s mismatch, expected %0d, got %0d", what, want, got);
        end
    endtask

    // Predict at the request handshake
    always @(posedge clk)
    begin
        wavg_rsp_t predicted;
        if (rst_n && req_valid && req_ready)
        begin
            if (advance_side_window(req, predicted))
            begin
                pushes_taken++;
                awaited_averages.push_back(req_fixed ? req_fixed_rsp : predicted);
            end
            else
                clears_taken++;
        end
    end

    // Check at the result handshake
    always @(posedge clk)
    begin
        wavg_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_averages.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result side %0d average %0d count %0d",
                             rsp.result_side, rsp.average, rsp.fill_count);
            end
            else
            begin
                want = awaited_averages.pop_front();
                averages_checked++;
                check_field("result_side", want.result_side, rsp.result_side);
                check_field("average", want.average, rsp.average);
                check_field("fill_count", want.fill_count, rsp.fill_count);
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (start_long_hold)
            begin
                start_long_hold = 1'b0;
                hold_left       = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Offer one item, maybe after a short gap, and return at its handshake
    // with valid still high.
    task automatic offer_item(input wavg_req_t item, input bit fixed,
                              input wavg_rsp_t fixed_rsp);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req           <= item;
        req_fixed     <= fixed;
        req_fixed_rsp <= fixed_rsp;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        // let the predictor log the item taken at this edge first
        @(posedge clk);
        while (awaited_averages.size() != 0)
            @(posedge clk);
        // a clear gives no result; let the block settle anyway
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [WLEN_W-1:0] value);
        wait_for_drain();
        window_length_we <= 1'b1;
        window_length    <= value;
        length_setting    = value;
        settings_used++;
        @(posedge clk);
        window_length_we <= 1'b0;
    endtask

    initial
    begin
        wavg_req_t         item;
        int unsigned       pick;
        logic [WLEN_W-1:0] len;
        logic [WLEN_W-1:0] phase_lengths [RANDOM_PHASES];

        phase_lengths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17,
                          5'd2, 5'd15, 5'd8, 5'd4, 5'd9, 5'd16};

        rst_n            <= 1'b0;
        req_valid        <= 1'b0;
        req              <= '0;
        req_fixed        <= 1'b0;
        req_fixed_rsp    <= '0;
        window_length_we <= 1'b0;
        window_length    <= WINDOW_LENGTH_RESET;
        cycle_count      = 0;
        mismatches       = 0;
        pushes_taken     = 0;
        clears_taken     = 0;
        averages_checked = 0;
        settings_used    = 0;
        start_long_hold  = 1'b0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        length_setting   = WINDOW_LENGTH_RESET;
        side_fill[0]     = 0;
        side_fill[1]     = 0;
        foreach (side_history[s, i])
            side_history[s][i] = '0;

        // extremes from reset, then clear, zero/over-range lengths, and a
        // length lowered below a side's fill count
        directed_rows.push_back(known_row(0, 4095, 4095, 1));
        directed_rows.push_back(known_row(0, 0, 2047, 2));
        directed_rows.push_back(known_row(1, 0, 0, 1));
        directed_rows.push_back(known_row(1, 4095, 2047, 2));
        directed_rows.push_back(clear_row());
        directed_rows.push_back(known_row(1, 1, 1, 1));
        directed_rows.push_back(known_row(0, 4094, 4094, 1));
        directed_rows.push_back(length_row(0));
        directed_rows.push_back(known_row(0, 100, 100, 1));
        directed_rows.push_back(known_row(0, 4095, 4095, 1));
        directed_rows.push_back(length_row(31));
        directed_rows.push_back(push_row(0, 2048));
        directed_rows.push_back(push_row(0, 4095));
        directed_rows.push_back(push_row(0, 1365));
        directed_rows.push_back(push_row(0, 2730));
        directed_rows.push_back(push_row(0, 7));
        directed_rows.push_back(length_row(2));
        directed_rows.push_back(push_row(0, 4095));
        directed_rows.push_back(push_row(1, 3000));
        directed_rows.push_back(length_row(1));
        directed_rows.push_back(push_row(1, 0));
        directed_rows.push_back(clear_row());
        directed_rows.push_back(known_row(1, 4095, 4095, 1));
        directed_rows.push_back(length_row(16));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].cfg_write)
                write_window_length(directed_rows[k].cfg_value);
            else
                offer_item(directed_rows[k].item, directed_rows[k].fixed,
                           directed_rows[k].fixed_rsp);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            len = (phase % 4 == 3 && phase != 3) ? WLEN_W'($urandom_range(0, 31))
                                                 : phase_lengths[phase];
            write_window_length(len);
            // last phase runs flat out; one middle phase runs without gaps too
            tx_idle_on = (phase != RANDOM_PHASES - 1) && (phase != 5);
            rx_idle_on = (phase != RANDOM_PHASES - 1) && (phase != 6);
            // fill the block up against a stalled receiver
            if (phase == 3)
                start_long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item.op   = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_PUSH;
                item.side = SIDE_W'($urandom_range(0, 1));
                pick      = $urandom_range(0, 7);
                if (pick == 0)
                    item.sample = '0;
                else if (pick == 1)
                    item.sample = '1;
                else
                    item.sample = SAMPLE_W'($urandom);
                offer_item(item, 1'b0, '0);
            end
        end

        wait_for_drain();

        $display("tb: %0d pushes and %0d clears taken, %0d averages checked",
                 pushes_taken, clears_taken, averages_checked);
        $display("tb: %0d window length settings, %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0 && awaited_averages.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
